// ----- design/idmu_pkg.sv -----
// Package: shared widths, opcode codes and data type of the divide/modulo unit.
package idmu_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH);
    localparam int OP_W       = 2;

    typedef enum logic [OP_W-1:0] {
        OP_SDIV = 2'd0,
        OP_SREM = 2'd1,
        OP_UDIV = 2'd2,
        OP_UREM = 2'd3
    } t_opcode;

    typedef logic [DATA_WIDTH-1:0] t_data;

endpackage

// ----- design/idmu_if.sv -----
// Interfaces: request and response channels of the divide/modulo unit.
interface idmu_req_if;
    import idmu_pkg::*;

    logic            valid;
    logic            ready;
    logic [OP_W-1:0] opcode;
    t_data           dividend;
    t_data           divisor;

    modport source (output valid, opcode, dividend, divisor, input ready);
    modport sink   (input valid, opcode, dividend, divisor, output ready);
endinterface

interface idmu_rsp_if;
    import idmu_pkg::*;

    logic  valid;
    logic  ready;
    t_data result;
    logic  div_by_zero;

    modport source (output valid, result, div_by_zero, input ready);
    modport sink   (input valid, result, div_by_zero, output ready);
endinterface

// ----- design/idmu_core.sv -----
// Unsigned radix-2 restoring divider, one quotient bit per cycle.
module idmu_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  idmu_pkg::t_data  i_dividend,
    input  idmu_pkg::t_data  i_divisor,
    output logic             o_busy,
    output idmu_pkg::t_data  o_quotient,
    output idmu_pkg::t_data  o_remainder
);
    import idmu_pkg::*;

    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    t_data              r_rem;
    t_data              r_quo;   // dividend bits shift out, quotient bits shift in
    t_data              r_dvs;

    logic [DATA_WIDTH:0] n_trial;
    logic [DATA_WIDTH:0] n_diff;
    logic                n_fits;

    assign n_trial = {r_rem, r_quo[DATA_WIDTH-1]};
    assign n_diff  = n_trial - {1'b0, r_dvs};
    assign n_fits  = !n_diff[DATA_WIDTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_quo  <= i_dividend;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= n_fits ? n_diff[DATA_WIDTH-1:0] : n_trial[DATA_WIDTH-1:0];
            r_quo  <= {r_quo[DATA_WIDTH-2:0], n_fits};
            r_cnt  <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DATA_WIDTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy      = r_busy;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ----- design/int32_divide_modulo_unit.sv -----
// Top level of the integer divide/modulo unit.
// Usage:
//   i_req carries opcode, dividend and divisor (valid/ready); a transaction
//   takes place on a rising edge with valid and ready both high. Opcodes:
//   signed quotient, signed remainder, unsigned quotient, unsigned remainder.
//   o_rsp carries result and div_by_zero, one transaction per request.
//   A request passes through the bit-serial divider (one quotient bit a cycle),
//   then through state S_FIX into the response register that drives o_rsp.
//   A zero divisor skips the divider and goes straight to S_FIX: response with
//   all ones (quotient) or the dividend (remainder) and div_by_zero set.
//   One request at a time: i_req.ready is high only in S_IDLE, not while a
//   division runs or its result waits in S_FIX for the response register.
//   Response stall: the response register holds its transaction while
//   o_rsp.ready is low; a new request is still taken and its result waits
//   in the divider until the response register frees up.
//   Reset (synchronous, active low) abandons any division in progress and
//   drops a pending response.
module int32_divide_modulo_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    idmu_req_if.sink   i_req,
    idmu_rsp_if.source o_rsp
);
    import idmu_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIX} t_state;

    t_state  r_state;
    logic    r_want_rem;
    logic    r_neg_q;
    logic    r_neg_r;
    logic    r_dz;
    t_data   r_dvd;
    logic    r_out_valid;
    t_data   r_res;
    logic    r_out_dz;

    t_opcode n_op;
    logic    n_acc;
    logic    n_want_rem;
    logic    n_signed;
    logic    n_nu;
    logic    n_nv;
    logic    n_dz;
    t_data   n_au;
    t_data   n_av;
    t_data   n_fix;
    logic    n_load;

    logic    core_busy;
    t_data   core_quo;
    t_data   core_rem;

    assign n_op       = t_opcode'(i_req.opcode);
    assign i_req.ready = (r_state == S_IDLE);
    assign n_acc      = i_req.valid && i_req.ready;
    assign n_want_rem = (n_op == OP_SREM) || (n_op == OP_UREM);
    assign n_signed   = (n_op == OP_SDIV) || (n_op == OP_SREM);
    assign n_nu       = n_signed && i_req.dividend[DATA_WIDTH-1];
    assign n_nv       = n_signed && i_req.divisor[DATA_WIDTH-1];
    assign n_au       = n_nu ? (~i_req.dividend + 1'b1) : i_req.dividend;
    assign n_av       = n_nv ? (~i_req.divisor + 1'b1) : i_req.divisor;
    assign n_dz       = (i_req.divisor == '0);

    idmu_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (n_acc && !n_dz),
        .i_dividend  (n_au),
        .i_divisor   (n_av),
        .o_busy      (core_busy),
        .o_quotient  (core_quo),
        .o_remainder (core_rem)
    );

    always_comb begin
        if (r_dz) begin
            n_fix = r_want_rem ? r_dvd : '1;
        end else if (r_want_rem) begin
            n_fix = r_neg_r ? (~core_rem + 1'b1) : core_rem;
        end else begin
            n_fix = r_neg_q ? (~core_quo + 1'b1) : core_quo;
        end
    end

    assign n_load = (r_state == S_FIX) && (!r_out_valid || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (n_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (n_acc) begin
                        r_want_rem <= n_want_rem;
                        r_neg_q    <= n_nu ^ n_nv;
                        r_neg_r    <= n_nu;
                        r_dz       <= n_dz;
                        r_dvd      <= i_req.dividend;
                        r_state    <= n_dz ? S_FIX : S_RUN;
                    end
                end
                S_RUN: begin
                    if (!core_busy) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    if (n_load) begin
                        r_res       <= n_fix;
                        r_out_dz    <= r_dz;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.result      = r_res;
    assign o_rsp.div_by_zero = r_out_dz;

    // divider only runs while the controller waits on it
    a_busy_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_busy |-> (r_state == S_RUN))
        else $error("divider busy outside run state");

    // a zero divisor bypasses the divider
    a_dz_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_acc && n_dz) |=> ((r_state == S_FIX) && !core_busy))
        else $error("zero divisor did not bypass divider");

    // a nonzero divisor starts the divider
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_acc && !n_dz) |=> (core_busy && (r_state == S_RUN)))
        else $error("divider did not start");

    // a response is loaded only when the register is free or being drained
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready && (r_state == S_FIX)) |=> (r_state == S_FIX))
        else $error("pending response overwritten");

endmodule

// ----- verif/int32_divide_modulo_unit_tb.sv -----
// Testbench: directed, back-pressure and random checks of the integer divide/modulo unit.
module int32_divide_modulo_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import idmu_pkg::*;

    localparam int    STALL_LIMIT = 2000;
    localparam int    LONG_HOLD   = 300;
    localparam int    N_RANDOM    = 150;
    localparam t_data MOST_NEG    = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef struct packed {
        t_data result;
        logic  div_by_zero;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;

    idmu_req_if req_if();
    idmu_rsp_if rsp_if();

    t_outcome exp_q[$];
    t_outcome exp_o;
    int       errors;
    int       idle_cycles;
    int       send_idle_pct;
    int       recv_idle_pct;
    logic     hold_on;
    event     hold_ev;

    int32_divide_modulo_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_outcome predict(input t_opcode op, input t_data u, input t_data v);
        t_outcome o;
        logic     want_rem;
        logic     is_signed;
        logic     nu;
        logic     nv;
        t_data    au;
        t_data    av;
        t_data    q;
        t_data    r;
        want_rem  = (op == OP_SREM) || (op == OP_UREM);
        is_signed = (op == OP_SDIV) || (op == OP_SREM);
        if (v == '0) begin
            o.result      = want_rem ? u : '1;
            o.div_by_zero = 1'b1;
            return o;
        end
        nu = is_signed && u[DATA_WIDTH-1];
        nv = is_signed && v[DATA_WIDTH-1];
        au = nu ? (~u + 1'b1) : u;
        av = nv ? (~v + 1'b1) : v;
        q  = au / av;
        r  = au % av;
        if (want_rem) begin
            o.result = nu ? (~r + 1'b1) : r;
        end else begin
            o.result = (nu != nv) ? (~q + 1'b1) : q;
        end
        o.div_by_zero = 1'b0;
        return o;
    endfunction

    function automatic t_data pick_operand();
        t_data v;
        case ($urandom_range(7))
            0: v = '0;
            1: v = MOST_NEG;
            2: v = '1;
            3: v = t_data'($urandom_range(15));
            4: v = ~t_data'($urandom_range(15));
            default: v = t_data'($urandom());
        endcase
        return v;
    endfunction

    task automatic send_item(input t_opcode op, input t_data dvd, input t_data dvs);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
        end
        req_if.valid    = 1'b1;
        req_if.opcode   = op;
        req_if.dividend = dvd;
        req_if.divisor  = dvs;
        @(posedge i_clk);
        while (!req_if.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        req_if.valid = 1'b0;
    endtask

    task automatic send_all_ops(input t_data dvd, input t_data dvs);
        send_item(OP_SDIV, dvd, dvs);
        send_item(OP_SREM, dvd, dvs);
        send_item(OP_UDIV, dvd, dvs);
        send_item(OP_UREM, dvd, dvs);
    endtask

    task automatic test_basic();
        send_all_ops(t_data'(100), t_data'(7));
        send_all_ops(t_data'(-100), t_data'(7));
        send_all_ops(t_data'(100), t_data'(-7));
        send_all_ops(t_data'(-100), t_data'(-7));
    endtask

    task automatic test_div_by_zero();
        send_all_ops(t_data'(12345), '0);
        send_all_ops(MOST_NEG, '0);
    endtask

    task automatic test_corner();
        send_all_ops(MOST_NEG, '1);
        send_all_ops(MOST_NEG, t_data'(1));
        send_all_ops(t_data'(5), t_data'(9));
        send_all_ops(t_data'(-5), t_data'(9));
        send_all_ops('1, t_data'(1));
        send_all_ops('0, t_data'(3));
        send_all_ops(~MOST_NEG, MOST_NEG);
    endtask

    task automatic test_random(input int n);
        repeat (n) begin
            send_item(t_opcode'(OP_W'($urandom_range(3))), pick_operand(), pick_operand());
        end
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_back_pressure();
        -> hold_ev;
        test_random(20);
    endtask

    initial begin : rx_hold
        hold_on = 1'b0;
        forever begin
            @(hold_ev);
            hold_on = 1'b1;
            repeat (LONG_HOLD) @(negedge i_clk);
            hold_on = 1'b0;
        end
    end

    initial begin : rx_drive
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_if.ready = !hold_on && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : scoreboard
        if (i_rst_n && req_if.valid && req_if.ready) begin
            exp_q.push_back(predict(t_opcode'(req_if.opcode), req_if.dividend,
                                    req_if.divisor));
        end
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (exp_q.size() == 0) begin
                $display("%0t unexpected transaction: expected none, actual %h dz %b",
                         $time, rsp_if.result, rsp_if.div_by_zero);
                errors++;
            end else begin
                exp_o = exp_q.pop_front();
                if (exp_o.result !== rsp_if.result ||
                    exp_o.div_by_zero !== rsp_if.div_by_zero) begin
                    $display("%0t mismatch: expected %h dz %b, actual %h dz %b",
                             $time, exp_o.result, exp_o.div_by_zero,
                             rsp_if.result, rsp_if.div_by_zero);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (req_if.valid && req_if.ready) ||
            (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t watchdog: no transaction for %0d cycles", $time, idle_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : main
        errors          = 0;
        idle_cycles     = 0;
        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.opcode   = OP_SDIV;
        req_if.dividend = '0;
        req_if.divisor  = '0;
        send_idle_pct   = 38;
        recv_idle_pct   = 68;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_basic();
        test_div_by_zero();
        test_corner();
        test_random(N_RANDOM);

        send_idle_pct = 68;
        recv_idle_pct = 38;
        test_random(N_RANDOM);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_back_pressure();
        test_random(N_RANDOM);

        while (exp_q.size() != 0) begin
            @(posedge i_clk);
        end
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/idmu_pkg.sv
design/idmu_if.sv
design/idmu_core.sv
design/int32_divide_modulo_unit.sv
verif/int32_divide_modulo_unit_tb.sv
